FILE: src/pfe_pkg.sv
// Package with shared constants and types for the postfix expression evaluator.
`timescale 1ns / 1ps

package pfe_pkg;

  // Stack geometry.
  localparam int unsigned StackDepth = 128;
  localparam int unsigned PtrW       = $clog2(StackDepth);
  localparam int unsigned CntW       = $clog2(StackDepth + 1);
  localparam int unsigned DataW      = 32;
  localparam int unsigned StepW      = $clog2(DataW);

  // Character codes.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChLPar  = 8'h28;
  localparam logic [7:0] ChRPar  = 8'h29;

  // Control word from the sequencer to the divider.
  typedef struct packed {
    logic start;
    logic want_rem;
  } div_ctrl_t;

  // Status word from the divider back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: src/pfe_div.sv
// Signed 32-bit divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module pfe_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pfe_pkg::div_ctrl_t       ctrl_i,
  input  logic [pfe_pkg::DataW-1:0] dividend_i,
  input  logic [pfe_pkg::DataW-1:0] divisor_i,
  output pfe_pkg::div_stat_t       stat_o,
  output logic [pfe_pkg::DataW-1:0] result_o
);
  import pfe_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] dvs_q, dvs_d;
  logic             qneg_q, qneg_d;
  logic             rneg_q, rneg_d;
  logic             want_rem_q, want_rem_d;
  logic [DataW:0]   shifted;
  logic [DataW:0]   diff;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign shifted = {rem_q, quo_q[DataW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d     = busy_q;
    done_d     = 1'b0;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    dvs_d      = dvs_q;
    qneg_d     = qneg_q;
    rneg_d     = rneg_q;
    want_rem_d = want_rem_q;
    if (ctrl_i.start) begin
      // Work on magnitudes; the most negative value stays correct as unsigned.
      busy_d     = 1'b1;
      cnt_d      = StepW'(DataW - 1);
      rem_d      = '0;
      quo_d      = dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
      dvs_d      = divisor_i[DataW-1] ? (~divisor_i + 1'b1) : divisor_i;
      qneg_d     = dividend_i[DataW-1] ^ divisor_i[DataW-1];
      rneg_d     = dividend_i[DataW-1];
      want_rem_d = ctrl_i.want_rem;
    end else if (busy_q) begin
      if (!diff[DataW]) begin
        rem_d = diff[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dvs_q      <= dvs_d;
    qneg_q     <= qneg_d;
    rneg_q     <= rneg_d;
    want_rem_q <= want_rem_d;
  end

  // Apply the signs: quotient by both operands, remainder by the dividend.
  always_comb begin
    if (want_rem_q) begin
      result_o = rneg_q ? (~rem_q + 1'b1) : rem_q;
    end else begin
      result_o = qneg_q ? (~quo_q + 1'b1) : quo_q;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: src/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator: stack, sequencer and ALU.
//
//  Channel | Direction | Handshake               | Fields
//  --------+-----------+-------------------------+---------------------------------------
//  input   | in        | in_valid_i / in_ready_o | symbol_char_i
//  output  | out       | out_valid_o/out_ready_i | result_value_o, stack_overflow_o,
//          |           |                         | divide_by_zero_o, stack_underflow_o
//
// An operand word is pushed as it is taken; + - * pop two words through the single registered
// read port, then run the ALU and push, and parentheses pop two words and push nothing.
// A / or % word runs the one-bit-per-cycle divider; a zero divisor pushes zero and flags it.
// A NUL word pops the result and then waits until the output register is free.
// Reset empties the stack and clears the flags; stack contents need no clearing.
// A stalled output only holds back the next NUL word; other words keep flowing.
`timescale 1ns / 1ps

module postfix_expression_evaluator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         symbol_char_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic               stack_overflow_o,
  output logic               divide_by_zero_o,
  output logic               stack_underflow_o
);
  import pfe_pkg::*;

  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StPop2 = 9'b000000010,
    StPop1 = 9'b000000100,
    StLoad = 9'b000001000,
    StExec = 9'b000010000,
    StDivW = 9'b000100000,
    StPush = 9'b001000000,
    StFin  = 9'b010000000,
    StEmit = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             dvz_q, dvz_d;
  logic             unf_q, unf_d;
  logic             out_valid_q, out_valid_d;

  logic [7:0]       char_q, char_d;
  logic [DataW-1:0] op_a_q, op_a_d;
  logic [DataW-1:0] op_b_q, op_b_d;
  logic [DataW-1:0] res_q, res_d;
  logic             pop_empty_q, pop_empty_d;
  logic [DataW-1:0] out_value_q, out_value_d;
  logic             out_ovf_q, out_ovf_d;
  logic             out_dvz_q, out_dvz_d;
  logic             out_unf_q, out_unf_d;

  // Stack memory with one write port and one registered read port.
  logic [DataW-1:0] stack_mem [StackDepth];
  logic [DataW-1:0] rdata_q;
  logic             wr_en;
  logic [PtrW-1:0]  wr_addr;
  logic [DataW-1:0] wr_data;
  logic             rd_en;
  logic [PtrW-1:0]  rd_addr;

  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [DataW-1:0] div_result;

  logic             in_fire;
  logic             stack_full;
  logic             stack_empty;
  logic [DataW-1:0] popped;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign stack_full  = (count_q == CntW'(StackDepth));
  assign stack_empty = (count_q == '0);
  assign popped      = pop_empty_q ? '1 : rdata_q;
  assign rd_addr     = PtrW'(count_q - 1'b1);
  assign wr_addr     = count_q[PtrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= stack_mem[rd_addr];
    end
  end

  pfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (op_a_q),
    .divisor_i  (op_b_q),
    .stat_o     (div_stat),
    .result_o   (div_result)
  );

  // Sequencer: pops through the read port, runs the ALU or divider, pushes.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    dvz_d       = dvz_q;
    unf_d       = unf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    res_d       = res_q;
    pop_empty_d = pop_empty_q;
    out_value_d = out_value_q;
    out_ovf_d   = out_ovf_q;
    out_dvz_d   = out_dvz_q;
    out_unf_d   = out_unf_q;
    wr_en       = 1'b0;
    wr_data     = res_q;
    rd_en       = 1'b0;
    div_ctrl    = '0;

    unique case (state_q) inside
      StIdle: begin
        if (in_fire) begin
          char_d = symbol_char_i;
          case (symbol_char_i) inside
            ChNul: begin
              state_d = StFin;
            end
            ChPlus, ChMinus, ChStar, ChSlash, ChPct, ChLPar, ChRPar: begin
              state_d = StPop2;
            end
            default: begin
              // Operand word: push its code minus the code of zero.
              wr_data = {24'b0, symbol_char_i} - {24'b0, ChZero};
              if (stack_full) begin
                ovf_d = 1'b1;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
          endcase
        end
      end
      StPop2, StPop1, StFin: begin
        pop_empty_d = stack_empty;
        if (stack_empty) begin
          unf_d = 1'b1;
        end else begin
          rd_en   = 1'b1;
          count_d = count_q - 1'b1;
        end
        if (state_q == StPop1) begin
          op_b_d = popped;
        end
        if (state_q == StPop2) begin
          state_d = StPop1;
        end else if (state_q == StPop1) begin
          state_d = StLoad;
        end else begin
          state_d = StEmit;
        end
      end
      StLoad: begin
        op_a_d = popped;
        if (char_q == ChLPar || char_q == ChRPar) begin
          state_d = StIdle;
        end else begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StPush;
        case (char_q)
          ChPlus:  res_d = op_a_q + op_b_q;
          ChMinus: res_d = op_a_q - op_b_q;
          ChStar:  res_d = DataW'(op_a_q * op_b_q);
          default: begin
            if (op_b_q == '0) begin
              res_d = '0;
              dvz_d = 1'b1;
            end else begin
              div_ctrl.start    = 1'b1;
              div_ctrl.want_rem = (char_q == ChPct);
              state_d           = StDivW;
            end
          end
        endcase
      end
      StDivW: begin
        if (div_stat.done) begin
          res_d   = div_result;
          state_d = StPush;
        end
      end
      StPush: begin
        if (stack_full) begin
          ovf_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end
        state_d = StIdle;
      end
      StEmit: begin
        // Load the result word once the output register is free, then restart.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_value_d = popped;
          out_ovf_d   = ovf_q;
          out_dvz_d   = dvz_q;
          out_unf_d   = unf_q;
          count_d     = '0;
          ovf_d       = 1'b0;
          dvz_d       = 1'b0;
          unf_d       = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      dvz_q       <= 1'b0;
      unf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      dvz_q       <= dvz_d;
      unf_q       <= unf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q      <= char_d;
    op_a_q      <= op_a_d;
    op_b_q      <= op_b_d;
    res_q       <= res_d;
    pop_empty_q <= pop_empty_d;
    out_value_q <= out_value_d;
    out_ovf_q   <= out_ovf_d;
    out_dvz_q   <= out_dvz_d;
    out_unf_q   <= out_unf_d;
  end

  // Output word.
  assign out_valid_o       = out_valid_q;
  assign result_value_o    = signed'(out_value_q);
  assign stack_overflow_o  = out_ovf_q;
  assign divide_by_zero_o  = out_dvz_q;
  assign stack_underflow_o = out_unf_q;

  logic unused_busy;
  assign unused_busy = div_stat.busy;

endmodule
